### hw/rtl/i2ctrf_pkg.sv
// ============================================================================
// i2ctrf_pkg: shared types and constants of the I2C target register file
// Register store geometry, event codes, write phases and the command bundle
// that the controller hands to the datapath.
// ============================================================================
package i2ctrf_pkg;

   // Number of byte registers behind the target.
   localparam int DEPTH = 16;

   // Store index width, and pointer width (the pointer may sit one past the end).
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PTR_W = $clog2(DEPTH + 1);

   // Byte event codes delivered by the bus front end.
   typedef enum logic [2:0] {
      CMD_ADDR_WRITE = 3'd0,
      CMD_DATA_WRITE = 3'd1,
      CMD_ADDR_READ  = 3'd2,
      CMD_DATA_READ  = 3'd3,
      CMD_NACK       = 3'd4
   } command_type;

   // Progress of a write transfer sequence.
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_POINTER = 2'd1,
      PH_DATA    = 2'd2
   } phase_type;

   // Commands from the controller to the datapath, all single-cycle strobes.
   typedef struct packed {
      logic clear_ptr;
      logic load_ptr;
      logic write_store;
      logic read_store;
   } dp_cmd_type;

endpackage

### hw/rtl/i2ctrf_datapath.sv
// ============================================================================
// i2ctrf_datapath: register store, pointer and read data register
// Executes the strobes from the controller on the store and the pointer.
// ============================================================================
module i2ctrf_datapath
   import i2ctrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type dp_cmd,
   input  logic [7:0] bus_byte,
   output logic [7:0] read_byte
);

   logic [7:0]       store_ff [DEPTH];
   logic [PTR_W-1:0] pointer_ff;
   logic [PTR_W-1:0] pointer_in;
   logic [7:0]       read_byte_ff;

   logic [PTR_W-1:0] ptr_wrapped;
   logic [PTR_W-1:0] ptr_next;
   logic [IDX_W-1:0] index;
   logic [8:0]       byte_wide;

   // A pointer left one past the end by a read wraps to the first entry.
   assign ptr_wrapped = (pointer_ff >= PTR_W'(DEPTH)) ? '0 : pointer_ff;
   assign ptr_next    = ptr_wrapped + PTR_W'(1);
   assign index       = ptr_wrapped[IDX_W-1:0];
   assign byte_wide   = {1'b0, bus_byte};

   always_comb begin
      pointer_in = pointer_ff;
      priority if (dp_cmd.clear_ptr) begin
         pointer_in = '0;
      end else if (dp_cmd.load_ptr) begin
         // An out-of-range pointer byte selects the first register.
         pointer_in = (byte_wide >= 9'(DEPTH)) ? '0 : byte_wide[PTR_W-1:0];
      end else if (dp_cmd.write_store) begin
         pointer_in = (ptr_next == PTR_W'(DEPTH)) ? '0 : ptr_next;
      end else if (dp_cmd.read_store) begin
         pointer_in = ptr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            store_ff[i] <= 8'h00;
         end
      end else begin
         pointer_ff <= pointer_in;
         if (dp_cmd.write_store) begin
            store_ff[index] <= bus_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.read_store) begin
         read_byte_ff <= store_ff[index];
      end
   end

   assign read_byte = read_byte_ff;

endmodule

### hw/rtl/i2ctrf_controller.sv
// ============================================================================
// i2ctrf_controller: write phase state machine and handshake control
// Decodes accepted events into datapath strobes and owns the result valid.
// ============================================================================
module i2ctrf_controller
   import i2ctrf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [2:0]  command,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  dp_cmd
);

   phase_type phase_ff;
   phase_type phase_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      is_read;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_read   = (command == CMD_ADDR_READ) || (command == CMD_DATA_READ);

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (command_type'(command))
            CMD_ADDR_WRITE: phase_in = PH_POINTER;
            CMD_DATA_WRITE: begin
               if (phase_ff == PH_POINTER) begin
                  phase_in = PH_DATA;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Outputs.
   always_comb begin
      dp_cmd = '0;
      if (accept) begin
         unique case (command_type'(command))
            CMD_ADDR_WRITE: dp_cmd.clear_ptr = 1'b1;
            CMD_DATA_WRITE: begin
               if (phase_ff == PH_POINTER) begin
                  dp_cmd.load_ptr = 1'b1;
               end else begin
                  dp_cmd.write_store = 1'b1;
               end
            end
            CMD_ADDR_READ,
            CMD_DATA_READ:  dp_cmd.read_store = 1'b1;
            default:        dp_cmd = '0;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && is_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/i2c_target_register_file_top.sv
// ============================================================================
// i2c_target_register_file_top: I2C target register file with auto increment
// Byte-event front end of an I2C target with a pointer-addressed byte store.
// ============================================================================
// Result: a read event's byte is offered on rsp in the cycle after its transfer.
// Throughput: one event per cycle; the single result register sets the pace,
// and a new event is taken whenever that register is empty or being drained.
// Reset: synchronous; clears the whole store, the pointer and the write phase,
// after which events are taken at once.
// ============================================================================
module i2c_target_register_file_top
   import i2ctrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // Event channel.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] bus_byte
   input  logic [2:0] req_tuser,   // [2:0] command
   // Result channel, one transfer per read event.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [7:0] read_byte
);

   dp_cmd_type dp_cmd;

   // The controller tracks where a write sequence stands (address seen,
   // pointer byte taken) and turns each accepted write or read event into one strobe.
   i2ctrf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .command   (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .dp_cmd    (dp_cmd)
   );

   // The datapath holds the store, the auto-incrementing pointer and the
   // registered read byte that is presented on the result channel.
   i2ctrf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .bus_byte  (req_tdata),
      .read_byte (rsp_tdata)
   );

endmodule
